/* src/trc_pkg.sv */
// ----------------------------------------------------------------------------
// TCP reply classifier package
// Shared types, register indexes, verdict codes and protocol constants.
// ----------------------------------------------------------------------------
package trc_pkg;

   typedef enum logic [2:0] {
      VERDICT_NOT_TCP     = 3'd0,
      VERDICT_TOO_SHORT   = 3'd1,
      VERDICT_OWN_PACKET  = 3'd2,
      VERDICT_UNRELATED   = 3'd3,
      VERDICT_OPEN        = 3'd4,
      VERDICT_CLOSED      = 3'd5,
      VERDICT_OTHER_REPLY = 3'd6
   } verdict_type;

   typedef enum logic [1:0] {
      CSR_LOCAL_ADDR   = 2'd0,
      CSR_TARGET_ADDR  = 2'd1,
      CSR_LOCAL_PORT   = 2'd2,
      CSR_SCANNED_PORT = 2'd3
   } csr_index_type;

   localparam logic [15:0] LocalPortReset   = 16'd12345;
   localparam logic [15:0] ScannedPortReset = 16'd80;

   localparam logic [7:0]  ProtoTcp  = 8'd6;
   localparam logic [7:0]  FlagSyn   = 8'h02;
   localparam logic [7:0]  FlagRst   = 8'h04;
   localparam logic [7:0]  FlagAck   = 8'h10;
   localparam logic [15:0] TcpMinLen = 16'd20;

   // Configuration as seen by the classifier.
   typedef struct packed {
      logic [31:0] local_addr;
      logic [31:0] target_addr;
      logic [15:0] local_port;
      logic [15:0] scanned_port;
   } cfg_type;

   // Header fields kept for one packet; len is the byte count.
   typedef struct packed {
      logic [15:0] len;
      logic [5:0]  header_bytes;
      logic [7:0]  proto;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] source_port;
      logic [15:0] dst_port;
      logic [31:0] seq;
      logic [7:0]  flags;
   } pkt_type;

endpackage

/* src/trc_csr.sv */
// ----------------------------------------------------------------------------
// TCP reply classifier register file
// APB-style write/read access to the address and port registers.
// ----------------------------------------------------------------------------
module trc_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [3:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready,
   output trc_pkg::cfg_type     cfg
);

   trc_pkg::cfg_type       cfg_ff;
   trc_pkg::cfg_type       cfg_in;
   trc_pkg::csr_index_type index;
   logic                   write_en;

   assign index    = trc_pkg::csr_index_type'(csr_paddr[3:2]);
   assign write_en = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            trc_pkg::CSR_LOCAL_ADDR:   cfg_in.local_addr   = csr_pwdata;
            trc_pkg::CSR_TARGET_ADDR:  cfg_in.target_addr  = csr_pwdata;
            trc_pkg::CSR_LOCAL_PORT:   cfg_in.local_port   = csr_pwdata[15:0];
            trc_pkg::CSR_SCANNED_PORT: cfg_in.scanned_port = csr_pwdata[15:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         trc_pkg::CSR_LOCAL_ADDR:   csr_prdata = cfg_ff.local_addr;
         trc_pkg::CSR_TARGET_ADDR:  csr_prdata = cfg_ff.target_addr;
         trc_pkg::CSR_LOCAL_PORT:   csr_prdata = {16'd0, cfg_ff.local_port};
         trc_pkg::CSR_SCANNED_PORT: csr_prdata = {16'd0, cfg_ff.scanned_port};
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.local_addr   <= '0;
         cfg_ff.target_addr  <= '0;
         cfg_ff.local_port   <= trc_pkg::LocalPortReset;
         cfg_ff.scanned_port <= trc_pkg::ScannedPortReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

/* src/trc_capture.sv */
// ----------------------------------------------------------------------------
// TCP reply classifier header capture
// Counts packet bytes and picks the IP and TCP header fields out of the stream.
// ----------------------------------------------------------------------------
module trc_capture #(
   parameter int MAX_PACKET = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic              last_accept,
   input  logic [7:0]        packet_byte,
   output trc_pkg::pkt_type  pkt
);

   localparam logic [15:0] MaxPacket   = 16'(MAX_PACKET);
   localparam logic [15:0] ProtoPos    = 16'd9;
   localparam logic [15:0] SrcAddrPos  = 16'd12;
   localparam logic [15:0] DstAddrPos  = 16'd16;
   localparam logic [15:0] TcpSeqPos   = 16'd4;
   localparam logic [15:0] TcpFlagsPos = 16'd13;

   trc_pkg::pkt_type state_ff;
   trc_pkg::pkt_type state_in;
   trc_pkg::pkt_type nxt;
   logic [15:0]      idx;
   logic [5:0]       hb_eff;
   logic [15:0]      tcp_off;

   // Byte 0 of a 32-bit word lands in the top bits, as on the wire.
   function automatic logic [31:0] put_byte32(input logic [31:0] word,
                                              input logic [1:0]  pos,
                                              input logic [7:0]  b);
      logic [31:0] w;
      w = word;
      unique case (pos)
         2'd0: w[31:24] = b;
         2'd1: w[23:16] = b;
         2'd2: w[15:8]  = b;
         2'd3: w[7:0]   = b;
         default: w = word;
      endcase
      return w;
   endfunction

   assign idx     = state_ff.len;
   // On byte 0 the header length it carries already applies to the TCP offset.
   assign hb_eff  = (idx == 16'd0) ? {packet_byte[3:0], 2'b00} : state_ff.header_bytes;
   assign tcp_off = idx - {10'd0, hb_eff};

   always_comb begin
      nxt = state_ff;
      if (idx < MaxPacket) begin
         if (idx == 16'd0) nxt.header_bytes = hb_eff;
         if (idx == ProtoPos) nxt.proto = packet_byte;
         if (idx >= SrcAddrPos && idx < DstAddrPos)
            nxt.src_addr = put_byte32(state_ff.src_addr, idx[1:0], packet_byte);
         if (idx >= DstAddrPos && idx < DstAddrPos + 16'd4)
            nxt.dst_addr = put_byte32(state_ff.dst_addr, idx[1:0], packet_byte);
         if (idx >= {10'd0, hb_eff}) begin
            if (tcp_off == 16'd0) nxt.source_port[15:8] = packet_byte;
            else if (tcp_off == 16'd1) nxt.source_port[7:0] = packet_byte;
            else if (tcp_off == 16'd2) nxt.dst_port[15:8] = packet_byte;
            else if (tcp_off == 16'd3) nxt.dst_port[7:0] = packet_byte;
            else if (tcp_off >= TcpSeqPos && tcp_off < TcpSeqPos + 16'd4)
               nxt.seq = put_byte32(state_ff.seq, tcp_off[1:0], packet_byte);
            else if (tcp_off == TcpFlagsPos) nxt.flags = packet_byte;
         end
      end
      nxt.len = (idx == 16'hFFFF) ? idx : idx + 16'd1;
   end

   always_comb begin
      pkt = nxt;
      pkt.len = (nxt.len < MaxPacket) ? nxt.len : MaxPacket;
   end

   always_comb begin
      if (last_accept) state_in = '0;
      else if (accept) state_in = nxt;
      else             state_in = state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* src/trc_decide.sv */
// ----------------------------------------------------------------------------
// TCP reply classifier verdict stage
// Holds the finished packet's fields, classifies them and drives the result.
// ----------------------------------------------------------------------------
module trc_decide (
   input  logic              clock,
   input  logic              reset,
   input  logic              last_accept,
   input  trc_pkg::pkt_type  pkt,
   input  trc_pkg::cfg_type  cfg,
   output logic              busy,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_verdict,
   output logic [7:0]        rsp_tcp_flags,
   output logic [31:0]       rsp_reset_ack
);

   logic                 snap_valid_ff;
   logic                 snap_valid_in;
   trc_pkg::pkt_type     snap_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [2:0]           verdict_ff;
   logic [7:0]           flags_ff;
   logic [31:0]          ack_ff;
   trc_pkg::verdict_type verdict;
   logic [7:0]           flags;
   logic [31:0]          ack;
   logic                 out_free;
   logic                 snap_move;
   logic                 own_pkt;
   logic                 reply;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign snap_move = snap_valid_ff && out_free;
   assign busy      = snap_valid_ff && !out_free;

   assign own_pkt = (snap_ff.src_addr == cfg.local_addr) &&
                    (snap_ff.dst_addr == cfg.target_addr);
   assign reply   = (snap_ff.src_addr == cfg.target_addr) &&
                    (snap_ff.dst_addr == cfg.local_addr) &&
                    (snap_ff.source_port == cfg.scanned_port) &&
                    (snap_ff.dst_port == cfg.local_port);

   always_comb begin
      flags = snap_ff.flags;
      ack   = snap_ff.seq + 32'd1;
      priority if (snap_ff.proto != trc_pkg::ProtoTcp) begin
         verdict = trc_pkg::VERDICT_NOT_TCP;
         flags   = '0;
         ack     = '0;
      end else if (snap_ff.len < {10'd0, snap_ff.header_bytes} + trc_pkg::TcpMinLen) begin
         verdict = trc_pkg::VERDICT_TOO_SHORT;
         flags   = '0;
         ack     = '0;
      end else if (own_pkt) begin
         verdict = trc_pkg::VERDICT_OWN_PACKET;
      end else if (reply) begin
         priority if (((snap_ff.flags & trc_pkg::FlagSyn) != 8'd0) &&
                      ((snap_ff.flags & trc_pkg::FlagAck) != 8'd0))
            verdict = trc_pkg::VERDICT_OPEN;
         else if ((snap_ff.flags & trc_pkg::FlagRst) != 8'd0)
            verdict = trc_pkg::VERDICT_CLOSED;
         else
            verdict = trc_pkg::VERDICT_OTHER_REPLY;
      end else begin
         verdict = trc_pkg::VERDICT_UNRELATED;
      end
   end

   always_comb begin
      if (last_accept)    snap_valid_in = 1'b1;
      else if (snap_move) snap_valid_in = 1'b0;
      else                snap_valid_in = snap_valid_ff;

      if (snap_move)      rsp_valid_in = 1'b1;
      else if (out_free)  rsp_valid_in = 1'b0;
      else                rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         snap_valid_ff <= snap_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (last_accept) snap_ff <= pkt;
      if (snap_move) begin
         verdict_ff <= verdict;
         flags_ff   <= flags;
         ack_ff     <= ack;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_verdict   = verdict_ff;
   assign rsp_tcp_flags = flags_ff;
   assign rsp_reset_ack = ack_ff;

endmodule

/* src/tcp_reply_classifier_core.sv */
// Throughput: one packet byte per cycle while req_stall is low, including back-to-back packets.
// The edge that transfers the last byte loads the packet register, and the result register
// loads from it once the result output is not stalled; the result outputs are registered.
// The input stalls only while a finished packet waits behind a stalled result.
// Reset is synchronous: it clears the byte count, kept fields and valid flags, and sets
// the registers to their defaults (addresses zero, local port 12345, scanned port 80).
// ----------------------------------------------------------------------------
// TCP reply classifier core
// Classifies a received IPv4 packet as a reply to a SYN probe or other traffic.
// ----------------------------------------------------------------------------
module tcp_reply_classifier_core #(
   parameter int MAX_PACKET = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_packet_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_verdict,
   output logic [7:0]  rsp_tcp_flags,
   output logic [31:0] rsp_reset_ack,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   trc_pkg::cfg_type cfg;
   trc_pkg::pkt_type pkt;
   logic             accept;
   logic             last_accept;
   logic             busy;

   assign req_stall   = busy;
   assign accept      = req_valid && !busy;
   assign last_accept = accept && req_last_byte;

   trc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   trc_capture #(
      .MAX_PACKET (MAX_PACKET)
   ) u_capture (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .last_accept (last_accept),
      .packet_byte (req_packet_byte),
      .pkt         (pkt)
   );

   trc_decide u_decide (
      .clock         (clock),
      .reset         (reset),
      .last_accept   (last_accept),
      .pkt           (pkt),
      .cfg           (cfg),
      .busy          (busy),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_verdict   (rsp_verdict),
      .rsp_tcp_flags (rsp_tcp_flags),
      .rsp_reset_ack (rsp_reset_ack)
   );

endmodule

/* src/trc_checker.sv */
// ----------------------------------------------------------------------------
// TCP reply classifier checker
// Port-level assertions on the result channel and the register port.
// ----------------------------------------------------------------------------
module trc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_verdict,
   input logic [7:0]  rsp_tcp_flags,
   input logic [31:0] rsp_reset_ack,
   input logic        csr_pready
);

   // A stalled result transfer holds its valid.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result valid dropped while stalled");

   // No verdict code above other_reply is ever produced.
   a_verdict_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_verdict <= trc_pkg::VERDICT_OTHER_REPLY))
      else $error("verdict code out of range");

   // Packets rejected before the address check carry no flags or ack.
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_verdict == trc_pkg::VERDICT_NOT_TCP ||
                    rsp_verdict == trc_pkg::VERDICT_TOO_SHORT)
      |-> (rsp_tcp_flags == 8'd0) && (rsp_reset_ack == 32'd0))
      else $error("rejected packet carries flags or ack");

   // An open verdict needs both SYN and ACK in the reported flags.
   a_open_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_verdict == trc_pkg::VERDICT_OPEN)
      |-> ((rsp_tcp_flags & trc_pkg::FlagSyn) != 8'd0) &&
          ((rsp_tcp_flags & trc_pkg::FlagAck) != 8'd0))
      else $error("open verdict without SYN and ACK");

   // Reset leaves no result pending, and the register port never waits.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && csr_pready)
      else $error("result pending or register port busy after reset");

endmodule

bind tcp_reply_classifier_core trc_checker u_trc_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_verdict   (rsp_verdict),
   .rsp_tcp_flags (rsp_tcp_flags),
   .rsp_reset_ack (rsp_reset_ack),
   .csr_pready    (csr_pready)
);
